>>> rtl/core/wlfo_pkg.sv
`default_nettype none

package wlfo_pkg;

  // Table geometry and phase format
  localparam int unsigned TABLE_DEPTH     = 1024;
  localparam int unsigned PHASE_FRAC_BITS = 16;
  localparam int unsigned IDX_W           = $clog2(TABLE_DEPTH);
  localparam int unsigned PHASE_W         = IDX_W + PHASE_FRAC_BITS;

  // Field widths
  localparam int unsigned STEP_W    = 26;
  localparam int unsigned WEIGHT_W  = 13;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned CFG_IDX_W = 1;

  // Interpolation accumulator: signed difference plus one guard bit
  localparam int unsigned DIFF_W = VALUE_W + 1;
  localparam int unsigned ACC_W  = VALUE_W + 2;

  // Shared bit counter for both serial multiplies
  localparam int unsigned CNT_W =
    $clog2((PHASE_FRAC_BITS > WEIGHT_W) ? PHASE_FRAC_BITS : WEIGHT_W);

  localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 12'd4095;
  localparam logic [WEIGHT_W-1:0] WEIGHT_UNITY = 13'd4096;

  // Input item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 1'b0,
    REG_AMP_WEIGHT = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> rtl/core/wlfo_ram.sv
`default_nettype none

module wlfo_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/wavetable_lfo_interpolating.sv
// Wavetable LFO with linear interpolation between adjacent table entries.
// Input channel (in_valid_i/in_ready_o): kind_i = 0 is a tick that yields one
// sample; kind_i = 1 stores table_value_i at table_index_i and yields nothing.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 sets the phase step,
// index 1 the amplitude weight (4096 is unity, larger values saturate).
// Output channel (out_valid_o/out_ready_i): wave_level_o and weighted_sample_o.
// A table write is stored as it is accepted. A tick reads two entries through
// the single table read port, interpolates with a bit-serial shift-add over the
// 16 fraction bits, clamps, then weights with a bit-serial multiply over the
// 13 weight bits and loads the output register. The next item is taken only
// once the sequencer is back in idle, so a tick is finished before another
// item is accepted.
// The output register frees the sequencer: a tick may be accepted and worked
// while the previous result waits; if that result is still not taken when the
// new one is finished, the sequencer holds and input ready stays low.
// Reset clears the phase and step to zero and sets the weight to unity. Table
// contents are undefined until written and are not cleared.
`default_nettype none

module wavetable_lfo_interpolating
  import wlfo_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [STEP_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [IDX_W-1:0]     table_index_i,
  input  wire logic [VALUE_W-1:0]   table_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [LEVEL_W-1:0]   wave_level_o,
  output logic      [SAMPLE_W-1:0]  weighted_sample_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_PREP,
    ST_INTERP,
    ST_LEVEL,
    ST_WEIGHT,
    ST_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [PHASE_W-1:0]    phase_q, phase_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [WEIGHT_W-1:0]   weight_q, weight_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]    out_level_q, out_level_d;
  logic [SAMPLE_W-1:0]   out_sample_q, out_sample_d;

  logic [VALUE_W-1:0]         y0_q, y0_d;
  logic [DIFF_W-1:0]          diff_q, diff_d;
  logic [PHASE_FRAC_BITS-1:0] frac_q, frac_d;
  logic [ACC_W-1:0]           acc_q, acc_d;
  logic [LEVEL_W-1:0]         level_q, level_d;
  logic [WEIGHT_W-1:0]        accw_q, accw_d;
  logic [WEIGHT_W-1:0]        mq_q, mq_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]     idx_lo;
  logic [IDX_W-1:0]     idx_hi;
  logic [ACC_W-1:0]     interp_add;
  logic [ACC_W-1:0]     interp_sum;
  logic [ACC_W-1:0]     level_sum;
  logic [WEIGHT_W-1:0]  weight_add;
  logic [WEIGHT_W-1:0]  weight_sum;
  logic [WEIGHT_W-1:0]  weight_sat;

  // Handshake outputs
  assign cfg_ready_o       = 1'b1;
  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign wave_level_o      = out_level_q;
  assign weighted_sample_o = out_sample_q;

  // Table: write on a write transaction, read low then high neighbour
  assign ram_we    = in_valid_i && in_ready_o && (kind_i == KIND_WRITE);
  assign idx_lo    = phase_q[PHASE_W-1 -: IDX_W];
  assign idx_hi    = idx_lo + IDX_W'(1);
  assign ram_raddr = (state_q == ST_RD_LO) ? idx_lo : idx_hi;

  wlfo_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (table_index_i),
    .wdata_i (table_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Serial interpolation step: add the difference on a set fraction bit, then
  // halve with sign extension so the result floors
  assign interp_add = frac_q[0] ? {diff_q[DIFF_W-1], diff_q} : '0;
  assign interp_sum = acc_q + interp_add;
  assign level_sum  = {2'b00, y0_q} + acc_q;

  // Serial weighting step: shift-add over the weight bits, low bits into mq
  assign weight_add = mq_q[0] ? {1'b0, level_q} : '0;
  assign weight_sum = accw_q + weight_add;
  assign weight_sat = (weight_q > WEIGHT_UNITY) ? WEIGHT_UNITY : weight_q;

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    step_d       = step_q;
    weight_d     = weight_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_level_d  = out_level_q;
    out_sample_d = out_sample_q;
    y0_d         = y0_q;
    diff_d       = diff_q;
    frac_d       = frac_q;
    acc_d        = acc_q;
    level_d      = level_q;
    accw_d       = accw_q;
    mq_d         = mq_q;

    // Take configuration writes
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_STEP: step_d   = cfg_data_i;
        REG_AMP_WEIGHT: weight_d = cfg_data_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (kind_i == KIND_TICK)) begin
          state_d = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        state_d = ST_RD_HI;
      end
      ST_RD_HI: begin
        y0_d    = ram_rdata;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        diff_d  = {1'b0, ram_rdata} - {1'b0, y0_q};
        frac_d  = phase_q[PHASE_FRAC_BITS-1:0];
        acc_d   = '0;
        cnt_d   = CNT_W'(PHASE_FRAC_BITS - 1);
        phase_d = phase_q + PHASE_W'(step_q);
        state_d = ST_INTERP;
      end
      ST_INTERP: begin
        acc_d  = {interp_sum[ACC_W-1], interp_sum[ACC_W-1:1]};
        frac_d = frac_q >> 1;
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        // Clamp the interpolated level
        level_d = (level_sum[ACC_W-1:LEVEL_W] != '0) ? LEVEL_MAX : level_sum[LEVEL_W-1:0];
        accw_d  = '0;
        mq_d    = weight_sat;
        cnt_d   = CNT_W'(WEIGHT_W - 1);
        state_d = ST_WEIGHT;
      end
      ST_WEIGHT: begin
        accw_d = {1'b0, weight_sum[WEIGHT_W-1:1]};
        mq_d   = {weight_sum[0], mq_q[WEIGHT_W-1:1]};
        cnt_d  = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_level_d  = level_q;
          out_sample_d = {accw_q[SAMPLE_W-WEIGHT_W-1:0], mq_q};
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= '0;
      step_q       <= '0;
      weight_q     <= WEIGHT_UNITY;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_level_q  <= '0;
      out_sample_q <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      step_q       <= step_d;
      weight_q     <= weight_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      out_level_q  <= out_level_d;
      out_sample_q <= out_sample_d;
    end
  end

  // Datapath shift registers and operands
  always_ff @(posedge clk_i) begin
    y0_q    <= y0_d;
    diff_q  <= diff_d;
    frac_q  <= frac_d;
    acc_q   <= acc_d;
    level_q <= level_d;
    accw_q  <= accw_d;
    mq_q    <= mq_d;
  end

  // A tick transaction starts the table reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == KIND_TICK)) |=> (state_q == ST_RD_LO))
    else $error("tick did not start the table reads");

  // The weighted sample never exceeds the level at unity weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weighted_sample_o <= {wave_level_o, 12'b0}))
    else $error("weighted sample above unity-gain level");

  // The phase advances only once per tick, as the fraction of the old phase is captured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_PREP) |=> (phase_q == $past(phase_q)))
    else $error("phase moved outside its update step");

endmodule

`default_nettype wire

>>> dv/wavetable_lfo_interpolating_test.sv
`timescale 1ns / 1ps

module wavetable_lfo_interpolating_test;
  import wlfo_pkg::*;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level;
    logic [SAMPLE_W-1:0] sample;
  } lfo_sample_t;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_valid_i       = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i       = '0;
  logic [STEP_W-1:0]    cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_ready_o;
  logic                 kind_i            = KIND_TICK;
  logic [IDX_W-1:0]     table_index_i     = '0;
  logic [VALUE_W-1:0]   table_value_i     = '0;
  logic                 out_valid_o;
  logic                 out_ready_i       = 1'b0;
  logic [LEVEL_W-1:0]   wave_level_o;
  logic [SAMPLE_W-1:0]  weighted_sample_o;

  // Oscillator state as the block should hold it
  logic [PHASE_W-1:0]   lfo_phase  = '0;
  logic [STEP_W-1:0]    lfo_step   = '0;
  logic [WEIGHT_W-1:0]  lfo_weight = WEIGHT_UNITY;
  logic [VALUE_W-1:0]   wave_mem     [TABLE_DEPTH];
  bit                   wave_written [TABLE_DEPTH];

  lfo_sample_t          expected_samples [$];
  int unsigned          error_count  = 0;
  int unsigned          items_issued = 0;
  bit                   idle_enabled = 1'b1;
  int unsigned          out_hold     = 0;

  wavetable_lfo_interpolating u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .table_index_i,
    .table_value_i,
    .out_valid_o,
    .out_ready_i,
    .wave_level_o,
    .weighted_sample_o
  );

  always #1 clk_i = ~clk_i;

  // Interpolate at the current phase, weight the level, then advance the phase
  function automatic lfo_sample_t advance_oscillator();
    logic [63:0] one, frac, acc, level, weight;
    int unsigned lo, hi;
    lfo_sample_t res;
    one    = 64'd1 << PHASE_FRAC_BITS;
    lo     = 32'(lfo_phase >> PHASE_FRAC_BITS);
    frac   = 64'(lfo_phase) & (one - 64'd1);
    hi     = (lo + 1) % TABLE_DEPTH;
    acc    = (64'(wave_mem[lo]) * (one - frac) + 64'(wave_mem[hi]) * frac) >> PHASE_FRAC_BITS;
    level  = (acc > 64'(LEVEL_MAX)) ? 64'(LEVEL_MAX) : acc;
    weight = (lfo_weight > WEIGHT_UNITY) ? 64'(WEIGHT_UNITY) : 64'(lfo_weight);
    res.level  = level[LEVEL_W-1:0];
    res.sample = SAMPLE_W'(level * weight);
    lfo_phase  = PHASE_W'((64'(lfo_phase) + 64'(lfo_step)) %
                          (64'(TABLE_DEPTH) << PHASE_FRAC_BITS));
    return res;
  endfunction

  // Mostly values below the clamp level, with some that overdrive it
  function automatic logic [VALUE_W-1:0] pick_wave_value();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return VALUE_W'($urandom_range(0, 4095));
      4:          return VALUE_W'($urandom_range(4000, 8191));
      5:          return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default:    return VALUE_W'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until the transaction completes, then update the state
  task automatic issue_lfo_item(input logic kind, input logic [IDX_W-1:0] idx,
                                input logic [VALUE_W-1:0] value);
    if (idle_enabled && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    table_index_i <= idx;
    table_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    items_issued++;
    if (kind == KIND_WRITE) begin
      if (idx < TABLE_DEPTH) begin
        wave_mem[idx]     = value;
        wave_written[idx] = 1'b1;
      end
    end else begin
      expected_samples.push_back(advance_oscillator());
    end
  endtask

  task automatic write_wave_entry(input int unsigned idx, input logic [VALUE_W-1:0] value);
    issue_lfo_item(KIND_WRITE, IDX_W'(idx), value);
  endtask

  // Fill both entries the tick will read if they were never written, then tick
  task automatic issue_tick();
    int unsigned lo, hi;
    lo = 32'(lfo_phase >> PHASE_FRAC_BITS);
    hi = (lo + 1) % TABLE_DEPTH;
    if (!wave_written[lo]) write_wave_entry(lo, pick_wave_value());
    if (!wave_written[hi]) write_wave_entry(hi, pick_wave_value());
    issue_lfo_item(KIND_TICK, IDX_W'($urandom), VALUE_W'($urandom));
  endtask

  // Hold off the input until every sample is back and the block has gone quiet
  task automatic drain_samples();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [STEP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PHASE_STEP: lfo_step   = data;
      REG_AMP_WEIGHT: lfo_weight = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_lfo(input logic [STEP_W-1:0] step, input logic [STEP_W-1:0] weight);
    drain_samples();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_AMP_WEIGHT, weight);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset values: zero step keeps the phase at entry 0, unity weight
  task automatic test_reset_state();
    write_wave_entry(0, VALUE_W'(4095));
    write_wave_entry(1, '0);
    issue_tick();
    issue_tick();
  endtask

  // Half-entry steps across zero, full scale and overdriven entries
  task automatic test_interpolation();
    program_lfo(STEP_W'(1) << (PHASE_FRAC_BITS - 1), STEP_W'(WEIGHT_UNITY));
    write_wave_entry(0, '0);
    write_wave_entry(1, VALUE_W'(4095));
    write_wave_entry(2, '1);
    write_wave_entry(3, VALUE_W'(1));
    repeat (6) issue_tick();
  endtask

  // Wrap onto entry 0 with the largest fraction, then wrap again with the largest step
  task automatic test_table_wrap();
    program_lfo((STEP_W'(TABLE_DEPTH - 3) << PHASE_FRAC_BITS) | STEP_W'('1 << 0) >> 10,
                STEP_W'(WEIGHT_UNITY));
    write_wave_entry(TABLE_DEPTH - 1, '0);
    write_wave_entry(0, VALUE_W'(4095));
    issue_tick();
    issue_tick();
    program_lfo('1, STEP_W'(WEIGHT_UNITY));
    issue_tick();
    issue_tick();
  endtask

  // Weight from zero to above unity on a full-scale level; junk in the upper data bits
  task automatic test_weight_range();
    logic [WEIGHT_W-1:0] weights [5];
    int unsigned lo;
    weights = '{13'd0, 13'd1, WEIGHT_UNITY, WEIGHT_UNITY + 13'd1, '1};
    lo = 32'(lfo_phase >> PHASE_FRAC_BITS);
    write_wave_entry(lo, VALUE_W'(4095));
    write_wave_entry((lo + 1) % TABLE_DEPTH, VALUE_W'(4095));
    foreach (weights[i]) begin
      program_lfo('0, {13'($urandom), weights[i]});
      issue_tick();
    end
  endtask

  function automatic logic [STEP_W-1:0] pick_step(input int sel);
    case (sel)
      0:       return '1;
      1:       return '0;
      default: begin
        case ($urandom_range(0, 3))
          0:       return STEP_W'($urandom_range(1, 1 << 18));
          1:       return STEP_W'($urandom);
          2:       return STEP_W'($urandom_range(0, TABLE_DEPTH - 1)) << PHASE_FRAC_BITS;
          default: return STEP_W'($urandom_range(0, (1 << PHASE_FRAC_BITS) - 1));
        endcase
      end
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_weight(input int sel);
    logic [WEIGHT_W-1:0] w;
    case (sel)
      0:       w = '1;
      1:       w = '0;
      default: begin
        case ($urandom_range(0, 3))
          0:       w = WEIGHT_UNITY;
          1:       w = WEIGHT_W'($urandom_range(0, WEIGHT_UNITY));
          2:       w = WEIGHT_W'($urandom_range(WEIGHT_UNITY, (1 << WEIGHT_W) - 1));
          default: w = WEIGHT_W'($urandom_range(3000, WEIGHT_UNITY));
        endcase
      end
    endcase
    return {13'($urandom), w};
  endfunction

  // Mixed ticks and table writes under one register setting
  task automatic run_traffic(input int sel, input int unsigned count);
    int unsigned target;
    program_lfo(pick_step(sel), pick_weight(sel));
    target = items_issued + count;
    while (items_issued < target) begin
      if ($urandom_range(0, 9) < 3)
        write_wave_entry($urandom_range(0, TABLE_DEPTH - 1), pick_wave_value());
      else
        issue_tick();
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 8; ph++) begin
      idle_enabled = (ph % 4) != 3;
      run_traffic(ph, 165);
    end
  endtask

  // Finish with back-to-back transactions and no stalls on either side
  task automatic test_quiet_tail();
    idle_enabled = 1'b0;
    run_traffic(2, 100);
  endtask

  // Stall the output in random bursts
  always @(posedge clk_i) begin
    if (out_hold != 0) begin
      out_hold <= out_hold - 1;
    end else if (idle_enabled && $urandom_range(0, 19) == 0) begin
      out_ready_i <= 1'b0;
      out_hold    <= $urandom_range(0, 15);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each sample transaction with the oldest expectation
  always @(posedge clk_i) begin
    lfo_sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample: wave_level %0d weighted_sample %0d",
               wave_level_o, weighted_sample_o);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (wave_level_o !== want.level) begin
          $error("wave_level: expected %0d, got %0d", want.level, wave_level_o);
          error_count++;
        end
        if (weighted_sample_o !== want.sample) begin
          $error("weighted_sample: expected %0d, got %0d", want.sample, weighted_sample_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_interpolation();
    test_table_wrap();
    test_weight_range();
    test_random_traffic();
    test_quiet_tail();
    drain_samples();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
